@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks, disabled while reset is asserted
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define CHK_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("check failed");

// antecedent at one edge implies consequent at the next edge
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

@@ rtl/sta_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sta_pkg
// shared types and constants of the sorted term accumulator
// ---------------------------------------------------------------------------
package sta_pkg;

	localparam int CAPACITY  = 16;
	localparam int EXP_WIDTH = 16;
	localparam int MAX_OUT   = 16;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int NOUT_MAX = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;

	// exponents are kept modulo 2^EXP_WIDTH, within the 16-bit field
	localparam logic [15:0] EXP_MASK =
		(EXP_WIDTH >= 16) ? 16'hFFFF : 16'((1 << EXP_WIDTH) - 1);

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] term_coef;
		logic [15:0]        term_exp;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_coef;
		logic [15:0]        out_exp;
		logic               last;
		logic               empty_res;
		logic               dropped;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] coef;
		logic [15:0]        exp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_PLACE,
		ST_STREAM,
		ST_EMPTY
	} state_t;

endpackage

@@ rtl/sorted_term_accumulator.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_term_accumulator
// sorted table of polynomial terms with saturating accumulation and readout
// ---------------------------------------------------------------------------
// The table holds up to CAPACITY terms in one synchronous memory, sorted by
// descending exponent. One input transaction is worked on at a time; the
// input is ready only while the sequencer is idle. An insert into an empty
// table is written straight into slot 0. Otherwise the sequencer scans
// from the top entry, one memory read per cycle: a matching exponent is
// accumulated in place (saturating), a term below every stored exponent
// is appended at the end of a table of n entries, and a new term further
// up opens a gap by moving every lower entry down one slot, read then
// write, one entry per cycle, and is then placed in the gap. A full table
// drops a new exponent as soon as the scan finds its place. A readout
// streams min(n, 16) results, one per cycle when the output is not
// stalled, behind a registered memory read; an empty table gives a single
// result flagged empty. The result register frees the input side, so a
// new transaction may be accepted while the last result waits.
// The sticky dropped and saturated flags only clear on reset; the memory has
// no reset and entries above the fill count are never read.
// ---------------------------------------------------------------------------
module sorted_term_accumulator
	import sta_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

`include "assert_macros.svh"

	// term memory, one entry per stored term
	entry_t mem [CAPACITY];
	entry_t rd_data_q;

	// sequencer and table state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;
	logic             sat_q;

	// captured insert term
	logic signed [31:0] coef_q;
	logic [15:0]        exp_q;

	// scan position, shift write slot, readout index
	logic [IDX_W-1:0] pos_q, pos_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
	logic             pend_q, pend_d;

	// result register
	logic      res_valid_q;
	out_item_t res_q;

	// memory port controls
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;

	logic      capture;
	logic      cnt_inc;
	logic      set_drop;
	logic      set_sat;
	logic      load_res;
	out_item_t res_d;

	logic             full;
	logic             res_free;
	logic [CNT_W-1:0] n_out;
	entry_t           new_entry;
	logic signed [32:0] sum_ext;
	logic signed [31:0] sum_sat;
	logic             sum_ovf;
	logic             ld;
	logic             issue;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign res_free = !res_valid_q || res_ready;
	assign n_out    = (count_q > CNT_W'(NOUT_MAX)) ? CNT_W'(NOUT_MAX) : count_q;

	assign new_entry = '{coef: coef_q, exp: exp_q};

	// saturating accumulate of the stored coefficient
	assign sum_ext = {rd_data_q.coef[31], rd_data_q.coef} + {coef_q[31], coef_q};
	assign sum_ovf = (sum_ext[32] != sum_ext[31]);
	assign sum_sat = !sum_ovf ? sum_ext[31:0] :
		(sum_ext[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		k_d       = k_q;
		rd_idx_d  = rd_idx_q;
		pend_d    = pend_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = new_entry;
		capture   = 1'b0;
		cnt_inc   = 1'b0;
		set_drop  = 1'b0;
		set_sat   = 1'b0;
		load_res  = 1'b0;
		res_d     = res_q;
		ld        = 1'b0;
		issue     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					capture = 1'b1;
					if (item.kind == KIND_INSERT) begin
						if (count_q == '0) begin
							// empty table: the term goes straight into slot 0
							mem_we    = 1'b1;
							mem_waddr = '0;
							mem_wdata = '{coef: item.term_coef, exp: item.term_exp & EXP_MASK};
							cnt_inc   = 1'b1;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							pos_d     = '0;
							state_d   = ST_SEARCH;
						end
					end else begin
						if (count_q == '0) begin
							state_d = ST_EMPTY;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							rd_idx_d  = CNT_W'(1);
							pend_d    = 1'b1;
							state_d   = ST_STREAM;
						end
					end
				end
			end

			ST_SEARCH: begin
				// rd_data_q holds the entry at pos_q
				if (rd_data_q.exp > exp_q) begin
					if (CNT_W'(pos_q) + CNT_W'(1) == count_q) begin
						// smaller than every stored exponent: append at the end
						if (full) begin
							set_drop = 1'b1;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = IDX_W'(count_q);
							cnt_inc   = 1'b1;
						end
						state_d = ST_IDLE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = pos_q + IDX_W'(1);
						pos_d     = pos_q + IDX_W'(1);
					end
				end else if (rd_data_q.exp == exp_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = '{coef: sum_sat, exp: exp_q};
					set_sat   = sum_ovf;
					state_d   = ST_IDLE;
				end else begin
					if (full) begin
						set_drop = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						// open a gap at pos_q, moving the tail down from the bottom
						mem_re    = 1'b1;
						mem_raddr = IDX_W'(count_q - CNT_W'(1));
						k_d       = IDX_W'(count_q);
						state_d   = ST_SHIFT;
					end
				end
			end

			ST_SHIFT: begin
				// rd_data_q holds entry k_q - 1, it moves to slot k_q
				mem_we    = 1'b1;
				mem_waddr = k_q;
				mem_wdata = rd_data_q;
				if (k_q - IDX_W'(1) == pos_q) begin
					state_d = ST_PLACE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = k_q - IDX_W'(2);
					k_d       = k_q - IDX_W'(1);
				end
			end

			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				cnt_inc   = 1'b1;
				state_d   = ST_IDLE;
			end

			ST_STREAM: begin
				// pend_q: rd_data_q holds entry rd_idx_q - 1, not yet sent
				ld    = pend_q && res_free;
				issue = (rd_idx_q < n_out) && (!pend_q || ld);
				if (ld) begin
					load_res = 1'b1;
					res_d    = '{out_coef: rd_data_q.coef, out_exp: rd_data_q.exp,
						last: (rd_idx_q == n_out), empty_res: 1'b0,
						dropped: drop_q, saturated: sat_q};
				end
				if (issue) begin
					mem_re    = 1'b1;
					mem_raddr = IDX_W'(rd_idx_q);
					rd_idx_d  = rd_idx_q + CNT_W'(1);
				end
				pend_d = issue || (pend_q && !ld);
				if (!pend_d) begin
					state_d = ST_IDLE;
				end
			end

			ST_EMPTY: begin
				if (res_free) begin
					load_res = 1'b1;
					res_d    = '{out_coef: '0, out_exp: '0, last: 1'b1, empty_res: 1'b1,
						dropped: drop_q, saturated: sat_q};
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			drop_q      <= 1'b0;
			sat_q       <= 1'b0;
			pos_q       <= '0;
			k_q         <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			k_q      <= k_d;
			rd_idx_q <= rd_idx_d;
			pend_q   <= pend_d;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (set_drop) begin
				drop_q <= 1'b1;
			end
			if (set_sat) begin
				sat_q <= 1'b1;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (capture) begin
			coef_q <= item.term_coef;
			exp_q  <= item.term_exp & EXP_MASK;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	// fill count stays within the table
	`CHK_ALWAYS(a_count_range, count_q <= CNT_W'(CAPACITY))
	// a move never writes at or above the gap it is opening
	`CHK_ALWAYS(a_shift_order, (state_q != ST_SHIFT) || (k_q > pos_q))
	// a readout leaves the fill count and the saturated flag untouched
	`CHK_NEXT(a_stream_stable, state_q == ST_STREAM, $stable(count_q) && $stable(sat_q))
	// pending read data always belongs to an issued entry
	`CHK_ALWAYS(a_pend_idx, !(state_q == ST_STREAM && pend_q) || (rd_idx_q != '0))

endmodule

@@ tb/sorted_term_accumulator_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_term_accumulator_tb
// self-checking bench for the sorted term accumulator
// ---------------------------------------------------------------------------
// A short table of directed transactions covers the corner cases: readout of
// an empty table, extreme coefficients and exponents, saturation both ways,
// a zero coefficient, filling the table, accumulation into a full table and
// a dropped term. Random transactions follow in three idling phases. Every
// accepted insert, and every readout without a hand-typed entry, is run
// through a local copy of the sorted term table, and each readout entry
// leaving the block is compared field by field with the oldest owed entry.
// ---------------------------------------------------------------------------
module sorted_term_accumulator_tb;

	import sta_pkg::*;

	localparam int            HOLD_CYCLES  = 300;
	localparam int            STALL_LIMIT  = 5000;
	localparam int            PHASE_ITEMS  = 68;
	localparam int            TAIL_CYCLES  = 40;
	localparam int            N_DIRECTED   = 26;
	localparam longint        COEF_TOP     = 64'sd2147483647;
	localparam longint        COEF_BOTTOM  = -64'sd2147483648;
	localparam logic [31:0]   COEF_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0]   COEF_MIN     = 32'h8000_0000;

	// one directed row: the transaction, plus a hand-typed readout entry
	typedef struct {
		in_item_t  txn;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      res_valid;
	logic      res_ready;
	out_item_t res;

	// local copy of the term table, advanced at each accepted insert
	logic [15:0]        term_exp_tbl  [CAPACITY];
	logic signed [31:0] term_coef_tbl [CAPACITY];
	int                 term_cnt;
	logic               drop_seen;
	logic               sat_seen;

	// readout entries the block still owes, oldest first
	out_item_t owed_entries [$];

	int        bad_cnt;
	int        snd_idle_pct;
	int        rcv_idle_pct;
	bit        hold_req;
	bit        hold_taken;
	int        hold_left;
	int        quiet_cycles;
	out_item_t want_entry;
	stim_row_t dir_rows [N_DIRECTED];

	sorted_term_accumulator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// add a term into the table: accumulate with clamping, or place it at its
	// sorted slot, or lose it when the table is full
	function automatic void table_insert(input logic signed [31:0] coef,
		input logic [15:0] ex_in);
		logic [15:0] ex;
		int          pos;
		longint      sum;
		ex  = ex_in & EXP_MASK;
		pos = 0;
		while (pos < term_cnt && term_exp_tbl[pos] > ex)
			pos++;
		if (pos < term_cnt && term_exp_tbl[pos] == ex) begin
			sum = longint'(term_coef_tbl[pos]) + longint'(coef);
			if (sum > COEF_TOP) begin
				sum      = COEF_TOP;
				sat_seen = 1'b1;
			end else if (sum < COEF_BOTTOM) begin
				sum      = COEF_BOTTOM;
				sat_seen = 1'b1;
			end
			term_coef_tbl[pos] = 32'(sum);
		end else if (term_cnt >= CAPACITY) begin
			drop_seen = 1'b1;
		end else begin
			for (int k = term_cnt; k > pos; k--) begin
				term_exp_tbl[k]  = term_exp_tbl[k - 1];
				term_coef_tbl[k] = term_coef_tbl[k - 1];
			end
			term_exp_tbl[pos]  = ex;
			term_coef_tbl[pos] = coef;
			term_cnt++;
		end
	endfunction

	// queue the entries a readout streams out, highest exponent first
	function automatic void table_readout();
		out_item_t e;
		int        n;
		if (term_cnt == 0) begin
			e = '{32'sd0, 16'h0000, 1'b1, 1'b1, drop_seen, sat_seen};
			owed_entries.push_back(e);
		end else begin
			n = (term_cnt < MAX_OUT) ? term_cnt : MAX_OUT;
			for (int k = 0; k < n; k++) begin
				e = '{term_coef_tbl[k], term_exp_tbl[k], (k == n - 1), 1'b0,
					drop_seen, sat_seen};
				owed_entries.push_back(e);
			end
		end
	endfunction

	// offer one transaction, with random idle cycles ahead of it, and book it
	// once accepted
	task automatic send_item(input in_item_t txn, input bit typed,
		input out_item_t want);
		while ($urandom_range(99) < snd_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= txn;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		if (txn.kind == KIND_INSERT)
			table_insert(txn.term_coef, txn.term_exp);
		else if (typed)
			owed_entries.push_back(want);
		else
			table_readout();
	endtask

	// stop offering and wait until every owed entry has come out
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (owed_entries.size() != 0);
	endtask

	// random transaction: mostly inserts, exponents mostly taken from the
	// table so that terms accumulate, coefficients often near the limits
	function automatic in_item_t random_item();
		in_item_t           txn;
		logic signed [31:0] coef;
		case ($urandom_range(3))
			0: coef = $urandom;
			1: coef = int'($urandom_range(200)) - 100;
			2: coef = $urandom_range(1) ? COEF_MAX : COEF_MIN;
			default: coef = int'($urandom_range(65535)) - 32768;
		endcase
		txn.kind      = ($urandom_range(5) == 0) ? KIND_READOUT : KIND_INSERT;
		txn.term_coef = coef;
		if (term_cnt != 0 && $urandom_range(3) != 0)
			txn.term_exp = term_exp_tbl[$urandom_range(term_cnt - 1)];
		else
			txn.term_exp = 16'($urandom);
		return txn;
	endfunction

	// result side: check each transaction against the oldest owed entry, then
	// decide ready for the next cycle (long hold-off once, when requested)
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (owed_entries.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("unexpected transaction: coef %0d exp %h last %b empty %b",
						res.out_coef, res.out_exp, res.last, res.empty_res);
			end else begin
				want_entry = owed_entries.pop_front();
				if (res.out_coef !== want_entry.out_coef ||
					res.out_exp !== want_entry.out_exp ||
					res.last !== want_entry.last ||
					res.empty_res !== want_entry.empty_res ||
					res.dropped !== want_entry.dropped ||
					res.saturated !== want_entry.saturated) begin
					bad_cnt++;
					if (bad_cnt <= 10) begin
						$display("mismatch: expected coef %0d exp %h last %b empty %b drop %b sat %b",
							want_entry.out_coef, want_entry.out_exp, want_entry.last,
							want_entry.empty_res, want_entry.dropped,
							want_entry.saturated);
						$display("          got coef %0d exp %h last %b empty %b drop %b sat %b",
							res.out_coef, res.out_exp, res.last,
							res.empty_res, res.dropped, res.saturated);
					end
				end
			end
		end
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		res_ready     = 1'b0;
		snd_idle_pct  = 18;
		rcv_idle_pct  = 73;
		hold_req      = 1'b0;
		hold_taken    = 1'b0;
		hold_left     = 0;
		quiet_cycles  = 0;
		bad_cnt       = 0;
		term_cnt      = 0;
		drop_seen     = 1'b0;
		sat_seen      = 1'b0;

		dir_rows = '{
			// empty table on readout
			'{'{KIND_READOUT, 32'sd0, 16'h0000}, 1'b1,
				'{32'sd0, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0}},
			// largest coefficient at the top exponent
			'{'{KIND_INSERT, COEF_MAX, 16'hFFFF}, 1'b0, '0},
			'{'{KIND_READOUT, 32'sd0, 16'h0000}, 1'b1,
				'{COEF_MAX, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
			// clamp at the top, sticky flag goes up
			'{'{KIND_INSERT, 32'sd1, 16'hFFFF}, 1'b0, '0},
			'{'{KIND_READOUT, 32'sd0, 16'h0000}, 1'b1,
				'{COEF_MAX, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1}},
			// smallest coefficient at exponent zero, then clamp at the bottom
			'{'{KIND_INSERT, COEF_MIN, 16'h0000}, 1'b0, '0},
			'{'{KIND_INSERT, -32'sd1, 16'h0000}, 1'b0, '0},
			// zero coefficient, and a sum that cancels to zero; both are kept
			'{'{KIND_INSERT, 32'sd0, 16'h8000}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd5, 16'h7FFF}, 1'b0, '0},
			'{'{KIND_INSERT, -32'sd5, 16'h7FFF}, 1'b0, '0},
			'{'{KIND_READOUT, 32'sd0, 16'h0000}, 1'b0, '0},
			// fill the table in scattered order so entries shift down
			'{'{KIND_INSERT, 32'sd11, 16'h0001}, 1'b0, '0},
			'{'{KIND_INSERT, -32'sd12, 16'hFFFE}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd100, 16'h4000}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd14, 16'hC000}, 1'b0, '0},
			'{'{KIND_INSERT, -32'sd15, 16'h0002}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd16, 16'h8001}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd17, 16'h7FFE}, 1'b0, '0},
			'{'{KIND_INSERT, -32'sd18, 16'h1234}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd19, 16'hABCD}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd20, 16'h00FF}, 1'b0, '0},
			'{'{KIND_INSERT, -32'sd21, 16'hF000}, 1'b0, '0},
			'{'{KIND_INSERT, 32'sd22, 16'h3000}, 1'b0, '0},
			// full table: a known exponent still accumulates
			'{'{KIND_INSERT, 32'sd9, 16'h4000}, 1'b0, '0},
			// full table: a new exponent is lost
			'{'{KIND_INSERT, 32'sd42, 16'h5555}, 1'b0, '0},
			'{'{KIND_READOUT, 32'sd0, 16'h0000}, 1'b0, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// phase 0: sender 18 / receiver 73, phase 1: swapped, phase 2: no idling,
		// opened by a long receiver hold-off so the block backs up its input
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 18;
					rcv_idle_pct = 73;
				end
				1: begin
					snd_idle_pct = 73;
					rcv_idle_pct = 18;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
					hold_req     = 1'b1;
				end
			endcase
			repeat (PHASE_ITEMS)
				send_item(random_item(), 1'b0, '0);
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_cnt == 0 && owed_entries.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sta_pkg.sv
rtl/sorted_term_accumulator.sv
tb/sorted_term_accumulator_tb.sv
